// ===== rtl/xcs_pkg.sv =====
// xcs_pkg: shared types, codes and constants for the xmodem checksum sender
// no dependencies; imported by every module of the block

package xcs_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_REPLY = 2'd1,
        OP_TICK  = 2'd2,
        OP_PULL  = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        PH_WAIT_START   = 8'b0000_0001,
        PH_LOAD         = 8'b0000_0010,
        PH_SEND         = 8'b0000_0100,
        PH_WAIT_REPLY   = 8'b0000_1000,
        PH_SEND_EOT     = 8'b0001_0000,
        PH_WAIT_EOT_ACK = 8'b0010_0000,
        PH_DONE         = 8'b0100_0000,
        PH_FAILED       = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        K_NONE     = 3'd0,
        K_FIXED    = 3'd1,
        K_DATA_MEM = 3'd2,
        K_DATA_PAD = 3'd3,
        K_SUM      = 3'd4
    } kind_t;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    localparam logic [1:0] ERR_NONE          = 2'd0;
    localparam logic [1:0] ERR_START_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_REPLY_TIMEOUT = 2'd2;
    localparam logic [1:0] ERR_EOT_TIMEOUT   = 2'd3;

    localparam logic [1:0] REG_START_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_PAD_BYTE      = 2'd2;

    localparam logic [15:0] START_TIMEOUT_RESET = 16'd60000;
    localparam logic [15:0] REPLY_TIMEOUT_RESET = 16'd10000;
    localparam logic [7:0]  PAD_BYTE_RESET      = 8'd26;

    localparam logic [7:0] BLOCK_NUMBER_RESET = 8'd1;

    typedef struct packed {
        logic [15:0] start_timeout;
        logic [15:0] reply_timeout;
        logic [7:0]  pad_byte;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] file_byte;
        logic       eof;
        logic [7:0] reply_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        kind_t      kind;
        logic [7:0] fixed_byte;
        logic       clear_sum;
        logic       frame_end;
        logic       load_taken;
        logic [2:0] phase;
        logic [1:0] error_code;
    } pipe_t;

    function automatic logic [2:0] phase_code(phase_t p);
        logic [2:0] code;
        unique case (p)
            PH_WAIT_START:   code = 3'd0;
            PH_LOAD:         code = 3'd1;
            PH_SEND:         code = 3'd2;
            PH_WAIT_REPLY:   code = 3'd3;
            PH_SEND_EOT:     code = 3'd4;
            PH_WAIT_EOT_ACK: code = 3'd5;
            PH_DONE:         code = 3'd6;
            PH_FAILED:       code = 3'd7;
            default:         code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/xmodem_checksum_sender.sv =====
// xmodem_checksum_sender: top level, configuration registers and the three stages
// depends on xcs_pkg, xcs_front, xcs_exec, xcs_out

// Sender side of XModem with an 8-bit checksum. Each input beat is one operation: load a
// file byte, hand in a receiver byte, a one-millisecond tick, or pull the next transmit
// byte; each beat yields exactly one result beat carrying the transmit byte (if any), the
// frame end mark, whether a load was taken, the phase and the error code. One beat per
// clock is sustained while out_stall is low; a beat is written into the input queue at
// the edge that takes it, then passes the protocol engine with its registered block
// buffer read, then the output register. The two-entry input queue keeps taking beats,
// until full, while a result waits on out_stall. The user must write the timeout and pad
// registers through cfg_we / cfg_index / cfg_data only while no beat is in flight; the
// block does not enforce this. Indexes past the last register are ignored.

module xmodem_checksum_sender #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    input  logic [7:0]  reply_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        frame_end,
    output logic        load_taken,
    output logic [2:0]  phase,
    output logic [1:0]  error_code
);
    import xcs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       head_valid;
    item_t      head;
    logic       head_pop;
    logic       pipe_valid;
    pipe_t      pipe;
    logic [7:0] rd_data;
    logic       pipe_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_TIMEOUT: cfg_next.start_timeout = cfg_data;
                REG_REPLY_TIMEOUT: cfg_next.reply_timeout = cfg_data;
                REG_PAD_BYTE:      cfg_next.pad_byte      = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_timeout <= START_TIMEOUT_RESET;
            cfg_reg.reply_timeout <= REPLY_TIMEOUT_RESET;
            cfg_reg.pad_byte      <= PAD_BYTE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    xcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .reply_byte  (reply_byte),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop)
    );

    xcs_exec #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .pipe_valid (pipe_valid),
        .pipe       (pipe),
        .rd_data    (rd_data),
        .pipe_take  (pipe_take)
    );

    xcs_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (pipe_valid),
        .pipe       (pipe),
        .rd_data    (rd_data),
        .pipe_take  (pipe_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .frame_end  (frame_end),
        .load_taken (load_taken),
        .phase      (phase),
        .error_code (error_code)
    );

endmodule

// ===== rtl/xcs_front.sv =====
// xcs_front: input side, takes beats, decodes the operation, two-entry queue
// depends on xcs_pkg

module xcs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    operation,
    input  logic [7:0]    file_byte,
    input  logic          end_of_file,
    input  logic [7:0]    reply_byte,
    output logic          head_valid,
    output xcs_pkg::item_t head,
    input  logic          head_pop
);
    import xcs_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    item_t      item_in;

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign pop        = head_pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.op         = op_t'(operation);
        item_in.file_byte  = file_byte;
        item_in.eof        = end_of_file;
        item_in.reply_byte = reply_byte;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/xcs_exec.sv =====
// xcs_exec: protocol engine, phase, counters, timer and the block buffer memory
// depends on xcs_pkg; feeds xcs_out through a registered stage

module xcs_exec #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  xcs_pkg::cfg_t  cfg,
    input  logic           head_valid,
    input  xcs_pkg::item_t head,
    output logic           head_pop,
    output logic           pipe_valid,
    output xcs_pkg::pipe_t pipe,
    output logic [7:0]     rd_data,
    input  logic           pipe_take
);
    import xcs_pkg::*;

    localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
    localparam int IDX_W  = $clog2(BLOCK_BYTES + 4);
    localparam int ADDR_W = $clog2(BLOCK_BYTES);

    logic [7:0]        mem [BLOCK_BYTES];
    logic [7:0]        rd_data_reg;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  fill_inc;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  k_idx;
    logic [7:0]        blk_reg;
    logic [7:0]        blk_next;
    logic [15:0]       timer_reg;
    logic [15:0]       timer_next;
    logic [15:0]       timer_inc;
    logic [15:0]       limit;
    logic [1:0]        fail_code;
    logic              file_done_reg;
    logic              file_done_next;
    logic [1:0]        err_reg;
    logic [1:0]        err_next;
    logic              pipe_valid_reg;
    logic              pipe_valid_next;
    pipe_t             pipe_reg;
    pipe_t             res;
    logic              fire;
    logic              wr_en;
    logic              rd_en;
    logic              in_wait;

    assign fire       = head_valid && (!pipe_valid_reg || pipe_take);
    assign head_pop   = fire;
    assign pipe_valid = pipe_valid_reg;
    assign pipe       = pipe_reg;
    assign rd_data    = rd_data_reg;

    assign fill_inc  = fill_reg + CNT_W'(1);
    assign k_idx     = idx_reg - IDX_W'(3);
    assign timer_inc = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;

    always_comb
    begin
        limit     = cfg.reply_timeout;
        fail_code = ERR_NONE;
        in_wait   = 1'b1;
        priority case (phase_reg)
            PH_WAIT_START:
            begin
                limit     = cfg.start_timeout;
                fail_code = ERR_START_TIMEOUT;
            end
            PH_WAIT_REPLY:   fail_code = ERR_REPLY_TIMEOUT;
            PH_WAIT_EOT_ACK: fail_code = ERR_EOT_TIMEOUT;
            default:         in_wait = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        blk_next       = blk_reg;
        timer_next     = timer_reg;
        file_done_next = file_done_reg;
        err_next       = err_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        res            = '0;
        res.kind       = K_NONE;

        if (fire)
        begin
            unique case (head.op)
                OP_LOAD:
                begin
                    if (phase_reg == PH_LOAD && fill_reg < CNT_W'(BLOCK_BYTES))
                    begin
                        wr_en          = 1'b1;
                        fill_next      = fill_inc;
                        res.load_taken = 1'b1;
                        if (head.eof)
                        begin
                            file_done_next = 1'b1;
                        end
                        if (head.eof || fill_inc == CNT_W'(BLOCK_BYTES))
                        begin
                            idx_next   = '0;
                            phase_next = PH_SEND;
                        end
                    end
                end
                OP_REPLY:
                begin
                    priority if (phase_reg == PH_WAIT_START)
                    begin
                        if (head.reply_byte == CH_NAK)
                        begin
                            phase_next = PH_LOAD;
                        end
                    end
                    else if (phase_reg == PH_WAIT_REPLY)
                    begin
                        if (head.reply_byte == CH_ACK)
                        begin
                            blk_next   = blk_reg + 8'd1;
                            fill_next  = '0;
                            idx_next   = '0;
                            phase_next = file_done_reg ? PH_SEND_EOT : PH_LOAD;
                        end
                        else if (head.reply_byte == CH_NAK)
                        begin
                            idx_next   = '0;
                            phase_next = PH_SEND;
                        end
                    end
                    else if (phase_reg == PH_WAIT_EOT_ACK)
                    begin
                        if (head.reply_byte == CH_ACK)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (in_wait)
                    begin
                        timer_next = timer_inc;
                        if (timer_inc >= limit)
                        begin
                            phase_next = PH_FAILED;
                            err_next   = fail_code;
                        end
                    end
                end
                OP_PULL:
                begin
                    if (phase_reg == PH_SEND)
                    begin
                        res.tx_valid = 1'b1;
                        idx_next     = idx_reg + IDX_W'(1);
                        priority if (idx_reg == IDX_W'(0))
                        begin
                            res.kind       = K_FIXED;
                            res.fixed_byte = CH_SOH;
                            res.clear_sum  = 1'b1;
                        end
                        else if (idx_reg == IDX_W'(1))
                        begin
                            res.kind       = K_FIXED;
                            res.fixed_byte = blk_reg;
                        end
                        else if (idx_reg == IDX_W'(2))
                        begin
                            res.kind       = K_FIXED;
                            res.fixed_byte = ~blk_reg;
                        end
                        else if (idx_reg < IDX_W'(BLOCK_BYTES + 3))
                        begin
                            if (k_idx < IDX_W'(fill_reg))
                            begin
                                res.kind = K_DATA_MEM;
                                rd_en    = 1'b1;
                            end
                            else
                            begin
                                res.kind       = K_DATA_PAD;
                                res.fixed_byte = cfg.pad_byte;
                            end
                        end
                        else
                        begin
                            res.kind      = K_SUM;
                            res.frame_end = 1'b1;
                            idx_next      = '0;
                            phase_next    = PH_WAIT_REPLY;
                            timer_next    = '0;
                        end
                    end
                    else if (phase_reg == PH_SEND_EOT)
                    begin
                        res.tx_valid   = 1'b1;
                        res.kind       = K_FIXED;
                        res.fixed_byte = CH_EOT;
                        res.frame_end  = 1'b1;
                        phase_next     = PH_WAIT_EOT_ACK;
                        timer_next     = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.phase      = phase_code(phase_next);
        res.error_code = err_next;

        if (fire)
        begin
            pipe_valid_next = 1'b1;
        end
        else if (pipe_take)
        begin
            pipe_valid_next = 1'b0;
        end
        else
        begin
            pipe_valid_next = pipe_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= head.file_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[k_idx[ADDR_W-1:0]];
        end
        if (fire)
        begin
            pipe_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_START;
            fill_reg       <= '0;
            idx_reg        <= '0;
            blk_reg        <= BLOCK_NUMBER_RESET;
            timer_reg      <= '0;
            file_done_reg  <= 1'b0;
            err_reg        <= ERR_NONE;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            blk_reg        <= blk_next;
            timer_reg      <= timer_next;
            file_done_reg  <= file_done_next;
            err_reg        <= err_next;
            pipe_valid_reg <= pipe_valid_next;
        end
    end

endmodule

// ===== rtl/xcs_out.sv =====
// xcs_out: result side, picks the transmit byte, keeps the running checksum,
// holds the result beat in the output register; depends on xcs_pkg

module xcs_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pipe_valid,
    input  xcs_pkg::pipe_t pipe,
    input  logic [7:0]     rd_data,
    output logic           pipe_take,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           tx_valid,
    output logic [7:0]     tx_byte,
    output logic           frame_end,
    output logic           load_taken,
    output logic [2:0]     phase,
    output logic [1:0]     error_code
);
    import xcs_pkg::*;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] byte_sel;
    logic       tx_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       frame_end_reg;
    logic       load_taken_reg;
    logic [2:0] phase_out_reg;
    logic [1:0] error_code_reg;

    assign pipe_take  = pipe_valid && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign tx_valid   = tx_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign frame_end  = frame_end_reg;
    assign load_taken = load_taken_reg;
    assign phase      = phase_out_reg;
    assign error_code = error_code_reg;

    always_comb
    begin
        sum_next = sum_reg;
        unique case (pipe.kind)
            K_NONE:     byte_sel = 8'd0;
            K_FIXED:    byte_sel = pipe.fixed_byte;
            K_DATA_MEM: byte_sel = rd_data;
            K_DATA_PAD: byte_sel = pipe.fixed_byte;
            K_SUM:      byte_sel = sum_reg;
            default:    byte_sel = 8'd0;
        endcase
        if (pipe_take)
        begin
            if (pipe.clear_sum)
            begin
                sum_next = 8'd0;
            end
            else if (pipe.kind == K_DATA_MEM || pipe.kind == K_DATA_PAD)
            begin
                sum_next = sum_reg + byte_sel;
            end
        end

        if (pipe_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_take)
        begin
            tx_valid_reg   <= pipe.tx_valid;
            tx_byte_reg    <= byte_sel;
            frame_end_reg  <= pipe.frame_end;
            load_taken_reg <= pipe.load_taken;
            phase_out_reg  <= pipe.phase;
            error_code_reg <= pipe.error_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
        end
    end

endmodule
